// File: rtl/ssts_pkg.sv
`timescale 1ns / 1ps

package ssts_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_BRIGHTNESS   = 2'd0;
  localparam logic [1:0] REG_DOT_EN       = 2'd1;
  localparam logic [1:0] REG_HALF_BIT     = 2'd2;
  localparam logic [1:0] REG_SHORT_PHASE  = 2'd3;

  // command bytes, the decimal point segment bit and the blank digit code
  localparam logic [7:0] CMD_DATA_AUTO   = 8'h44;
  localparam logic [7:0] CMD_ADDRESS     = 8'hc0;
  localparam logic [7:0] CMD_DISPLAY_CTL = 8'h88;
  localparam logic [7:0] SEG_POINT       = 8'h80;
  localparam logic [6:0] DIGIT_BLANK     = 7'h7f;

  localparam logic [7:0] HALF_BIT_RESET    = 8'd10;
  localparam logic [7:0] SHORT_PHASE_RESET = 8'd2;

  typedef struct packed {
    logic [2:0] brightness;
    logic       dot_en;
    logic [7:0] half_bit_ticks;
    logic [7:0] short_phase_ticks;
  } cfg_t;

  // per-tick line levels and status, lowest field last
  typedef struct packed {
    logic bad_digit;
    logic waiting_ack;
    logic done_res;
    logic busy_res;
    logic data_drive;
    logic data_line_out;
    logic clock_line;
  } line_res_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'h0: seg = 8'h3f;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5b;
      4'h3: seg = 8'h4f;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6d;
      4'h6: seg = 8'h7d;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7f;
      4'h9: seg = 8'h6f;
      4'ha: seg = 8'h77;
      4'hb: seg = 8'h7c;
      4'hc: seg = 8'h39;
      4'hd: seg = 8'h5e;
      4'he: seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

// File: rtl/ssts_line_seq.sv
`timescale 1ns / 1ps

module ssts_line_seq #(
  parameter int TICK_COUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               request,
  input  logic [1:0]         position,
  input  logic [6:0]         digit_code,
  input  logic               data_line_in,
  input  ssts_pkg::cfg_t     cfg,
  output ssts_pkg::line_res_t res
);
  import ssts_pkg::*;

  localparam int CMP_BITS = ((TICK_COUNT_BITS > 8) ? TICK_COUNT_BITS : 8) + 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW,
    PH_ACK_HIGH, PH_ACK_WAIT, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  phase_t                     phase, phase_next;
  logic [1:0]                 transaction_index, transaction_index_next;
  logic                       byte_index, byte_index_next;
  logic [3:0]                 bit_count, bit_count_next;
  logic [TICK_COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [7:0]                 shift_byte, shift_byte_next;
  logic [7:0]                 segment_latch, segment_latch_next;
  logic [1:0]                 position_latch, position_latch_next;
  logic                       error_latch, error_latch_next;

  logic [7:0] limit;
  logic       over;
  logic [7:0] load_value;
  logic [3:0] bit_count_inc;

  assign limit = (phase == PH_BIT_LOW || phase == PH_BIT_HIGH) ? cfg.half_bit_ticks
                                                              : cfg.short_phase_ticks;
  assign over = (CMP_BITS'(tick_count) + CMP_BITS'(1) >= CMP_BITS'(limit)) ||
                (tick_count == {TICK_COUNT_BITS{1'b1}});
  assign bit_count_inc = bit_count + 4'd1;

  // first byte of a frame, loaded at the end of the start condition
  always_comb begin
    if (transaction_index == 2'd0) begin
      load_value = CMD_DATA_AUTO;
    end else if (transaction_index == 2'd1) begin
      load_value = byte_index ? segment_latch : (CMD_ADDRESS | {6'd0, position_latch});
    end else begin
      load_value = CMD_DISPLAY_CTL + {5'd0, cfg.brightness};
    end
  end

  always_comb begin
    phase_next             = phase;
    transaction_index_next = transaction_index;
    byte_index_next        = byte_index;
    bit_count_next         = bit_count;
    tick_count_next        = tick_count + TICK_COUNT_BITS'(1);
    shift_byte_next        = shift_byte;
    segment_latch_next     = segment_latch;
    position_latch_next    = position_latch;
    error_latch_next       = error_latch;

    res               = '0;
    res.clock_line    = 1'b1;
    res.data_line_out = 1'b1;
    res.data_drive    = 1'b1;
    res.busy_res      = (phase != PH_IDLE);

    case (phase)
      PH_START_B:  res.data_line_out = 1'b0;
      PH_BIT_LOW:  begin
        res.clock_line    = 1'b0;
        res.data_line_out = shift_byte[0];
      end
      PH_BIT_HIGH: res.data_line_out = shift_byte[0];
      PH_ACK_LOW:  res.clock_line = 1'b0;
      PH_ACK_WAIT: begin
        res.data_drive  = 1'b0;
        res.waiting_ack = 1'b1;
      end
      PH_STOP_A:   res.clock_line = 1'b0;
      PH_STOP_B:   begin
        res.clock_line    = 1'b0;
        res.data_line_out = 1'b0;
      end
      PH_STOP_C:   res.data_line_out = 1'b0;
      default:     ;
    endcase

    case (phase)
      PH_IDLE: begin
        tick_count_next = tick_count;
        if (request) begin
          position_latch_next = position;
          if (digit_code < 7'd16) begin
            segment_latch_next = seg_encode(digit_code[3:0]) | (cfg.dot_en ? SEG_POINT : 8'd0);
            error_latch_next   = 1'b0;
          end else begin
            segment_latch_next = cfg.dot_en ? SEG_POINT : 8'd0;
            error_latch_next   = (digit_code != DIGIT_BLANK);
          end
          transaction_index_next = 2'd0;
          byte_index_next        = 1'b0;
          phase_next             = PH_START_A;
          tick_count_next        = '0;
        end
      end
      PH_START_A: if (over) begin
        phase_next      = PH_START_B;
        tick_count_next = '0;
      end
      PH_START_B: if (over) begin
        shift_byte_next = load_value;
        bit_count_next  = 4'd0;
        phase_next      = PH_BIT_LOW;
        tick_count_next = '0;
      end
      PH_BIT_LOW: if (over) begin
        phase_next      = PH_BIT_HIGH;
        tick_count_next = '0;
      end
      PH_BIT_HIGH: if (over) begin
        shift_byte_next = shift_byte >> 1;
        bit_count_next  = bit_count_inc;
        phase_next      = (bit_count_inc >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
        tick_count_next = '0;
      end
      PH_ACK_LOW: if (over) begin
        phase_next      = PH_ACK_HIGH;
        tick_count_next = '0;
      end
      PH_ACK_HIGH: if (over) begin
        phase_next      = PH_ACK_WAIT;
        tick_count_next = '0;
      end
      PH_ACK_WAIT: begin
        tick_count_next = tick_count;
        if (!data_line_in) begin
          tick_count_next = '0;
          if (transaction_index == 2'd1 && !byte_index) begin
            // address byte acknowledged, segments follow in the same frame
            byte_index_next = 1'b1;
            shift_byte_next = segment_latch;
            bit_count_next  = 4'd0;
            phase_next      = PH_BIT_LOW;
          end else begin
            phase_next = PH_STOP_A;
          end
        end
      end
      PH_STOP_A: if (over) begin
        phase_next      = PH_STOP_B;
        tick_count_next = '0;
      end
      PH_STOP_B: if (over) begin
        phase_next      = PH_STOP_C;
        tick_count_next = '0;
      end
      PH_STOP_C: if (over) begin
        tick_count_next = '0;
        byte_index_next = 1'b0;
        if (transaction_index >= 2'd2) begin
          res.done_res           = 1'b1;
          transaction_index_next = 2'd0;
          phase_next             = PH_IDLE;
        end else begin
          transaction_index_next = transaction_index + 2'd1;
          phase_next             = PH_START_A;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    res.bad_digit = error_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      transaction_index <= 2'd0;
      byte_index        <= 1'b0;
      bit_count         <= 4'd0;
      tick_count        <= '0;
      shift_byte        <= 8'd0;
      segment_latch     <= 8'd0;
      position_latch    <= 2'd0;
      error_latch       <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      transaction_index <= transaction_index_next;
      byte_index        <= byte_index_next;
      bit_count         <= bit_count_next;
      tick_count        <= tick_count_next;
      shift_byte        <= shift_byte_next;
      segment_latch     <= segment_latch_next;
      position_latch    <= position_latch_next;
      error_latch       <= error_latch_next;
    end
  end

endmodule

// File: rtl/seven_segment_two_wire_sender.sv
`timescale 1ns / 1ps

// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready | one timing tick: request, position,
//           |     |                            | digit_code, data_line_in
// m_axis    | out | m_axis_tvalid/m_axis_tready | line levels and status of that tick
// cfg       | in  | cfg_wr_en (no wait)        | cfg_addr, cfg_wdata
//
// every accepted item is one tick of the line sequencer; its result sits in the
// output register in the next cycle; with m_axis_tready high one item per cycle
// is sustained; the sequencer state and the output register advance together on
// acceptance; s_axis_tready drops only while a result waits and m_axis_tready is low
// reset (rst, synchronous) returns the sequencer to idle with clock and data
// driven high and loads the configuration defaults

module seven_segment_two_wire_sender #(
  parameter int TICK_COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] request, [2:1] position, [9:3] digit_code, [10] data_line_in, [15:11] zero
  input  logic [15:0] s_axis_tdata,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] clock_line, [1] data_line_out, [2] data_drive, [3] busy_res,
  // [4] done_res, [5] waiting_ack, [6] bad_digit, [7] zero
  output logic [7:0]  m_axis_tdata,

  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import ssts_pkg::*;

  cfg_t      cfg;
  line_res_t tick_res;
  logic      step;
  logic      out_valid;
  logic [7:0] out_data;

  // output register frees up in the same cycle it is taken
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness        <= 3'd0;
      cfg.dot_en            <= 1'b0;
      cfg.half_bit_ticks    <= HALF_BIT_RESET;
      cfg.short_phase_ticks <= SHORT_PHASE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_BRIGHTNESS:  cfg.brightness        <= cfg_wdata[2:0];
        REG_DOT_EN:      cfg.dot_en            <= cfg_wdata[0];
        REG_HALF_BIT:    cfg.half_bit_ticks    <= cfg_wdata;
        REG_SHORT_PHASE: cfg.short_phase_ticks <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  ssts_line_seq #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .request      (s_axis_tdata[0]),
    .position     (s_axis_tdata[2:1]),
    .digit_code   (s_axis_tdata[9:3]),
    .data_line_in (s_axis_tdata[10]),
    .cfg          (cfg),
    .res          (tick_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= {1'b0, tick_res};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssts_pkg::*;

  localparam int CYCLE_LIMIT = 40000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_BIT_LOW, SEQ_BIT_HIGH, SEQ_ACK_LOW,
    SEQ_ACK_HIGH, SEQ_ACK_WAIT, SEQ_STOP_A, SEQ_STOP_B, SEQ_STOP_C
  } seq_phase_t;

  // line sequencer mirror: per accepted tick it works out the line levels due
  class line_level_board;
    cfg_t        cfg;
    seq_phase_t  phase;
    logic [1:0]  xact;
    logic        byte_sel;
    logic [3:0]  bits_sent;
    logic [7:0]  ticks;
    logic [7:0]  shifter;
    logic [7:0]  seg_hold;
    logic [1:0]  pos_hold;
    logic        err_hold;
    logic [7:0]  seg_map [16];
    string       field_names [7];
    line_res_t   levels_due [$];
    int          mismatches;
    int          results_seen;

    function new();
      seg_map = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
                  8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71};
      field_names = '{"clock_line", "data_line_out", "data_drive", "busy_res",
                      "done_res", "waiting_ack", "bad_digit"};
      cfg.brightness = 3'd0;
      cfg.dot_en = 1'b0;
      cfg.half_bit_ticks = HALF_BIT_RESET;
      cfg.short_phase_ticks = SHORT_PHASE_RESET;
      phase = SEQ_IDLE;
      xact = '0;
      byte_sel = 1'b0;
      bits_sent = '0;
      ticks = '0;
      shifter = '0;
      seg_hold = '0;
      pos_hold = '0;
      err_hold = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        REG_BRIGHTNESS:  cfg.brightness = v[2:0];
        REG_DOT_EN:      cfg.dot_en = v[0];
        REG_HALF_BIT:    cfg.half_bit_ticks = v;
        REG_SHORT_PHASE: cfg.short_phase_ticks = v;
        default: ;
      endcase
    endfunction

    function bit idle();
      return phase == SEQ_IDLE;
    endfunction

    function bit in_ack_wait();
      return phase == SEQ_ACK_WAIT;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function void go(seq_phase_t nxt);
      phase = nxt;
      ticks = '0;
    endfunction

    function void load_byte();
      if (xact == 2'd0) shifter = CMD_DATA_AUTO;
      else if (xact == 2'd1) shifter = byte_sel ? seg_hold : (CMD_ADDRESS | {6'b0, pos_hold});
      else shifter = CMD_DISPLAY_CTL + {5'b0, cfg.brightness};
      bits_sent = '0;
      go(SEQ_BIT_LOW);
    endfunction

    function void note_tick(logic [15:0] item);
      logic       req;
      logic [1:0] pos;
      logic [6:0] dig;
      logic       din;
      logic [7:0] lim;
      logic [7:0] pt;
      bit         over;
      line_res_t  r;
      req = item[0];
      pos = item[2:1];
      dig = item[9:3];
      din = item[10];
      r = '0;
      r.clock_line = 1'b1;
      r.data_line_out = 1'b1;
      r.data_drive = 1'b1;
      r.busy_res = (phase != SEQ_IDLE);
      case (phase)
        SEQ_START_B: r.data_line_out = 1'b0;
        SEQ_BIT_LOW: begin
          r.clock_line = 1'b0;
          r.data_line_out = shifter[0];
        end
        SEQ_BIT_HIGH: r.data_line_out = shifter[0];
        SEQ_ACK_LOW:  r.clock_line = 1'b0;
        SEQ_ACK_WAIT: begin
          r.data_drive = 1'b0;
          r.waiting_ack = 1'b1;
        end
        SEQ_STOP_A: r.clock_line = 1'b0;
        SEQ_STOP_B: begin
          r.clock_line = 1'b0;
          r.data_line_out = 1'b0;
        end
        SEQ_STOP_C: r.data_line_out = 1'b0;
        default: ;
      endcase

      lim = (phase == SEQ_BIT_LOW || phase == SEQ_BIT_HIGH) ? cfg.half_bit_ticks
                                                            : cfg.short_phase_ticks;
      // a zero limit still lasts one tick; an all-ones counter always ends the phase
      over = (int'(ticks) + 1 >= int'(lim)) || (ticks == 8'hff);

      case (phase)
        SEQ_IDLE: begin
          if (req) begin
            pt = cfg.dot_en ? SEG_POINT : 8'h00;
            pos_hold = pos;
            if (dig < 7'd16) begin
              seg_hold = seg_map[dig[3:0]] | pt;
              err_hold = 1'b0;
            end else begin
              seg_hold = pt;
              err_hold = (dig != DIGIT_BLANK);
            end
            xact = '0;
            byte_sel = 1'b0;
            go(SEQ_START_A);
          end
        end
        SEQ_START_A:  if (over) go(SEQ_START_B); else ticks++;
        SEQ_START_B:  if (over) load_byte(); else ticks++;
        SEQ_BIT_LOW:  if (over) go(SEQ_BIT_HIGH); else ticks++;
        SEQ_BIT_HIGH: begin
          if (over) begin
            shifter = shifter >> 1;
            bits_sent = bits_sent + 4'd1;
            go(bits_sent >= 4'd8 ? SEQ_ACK_LOW : SEQ_BIT_LOW);
          end else ticks++;
        end
        SEQ_ACK_LOW:  if (over) go(SEQ_ACK_HIGH); else ticks++;
        SEQ_ACK_HIGH: if (over) go(SEQ_ACK_WAIT); else ticks++;
        SEQ_ACK_WAIT: begin
          if (!din) begin
            if (xact == 2'd1 && !byte_sel) begin
              byte_sel = 1'b1;
              load_byte();
            end else go(SEQ_STOP_A);
          end
        end
        SEQ_STOP_A: if (over) go(SEQ_STOP_B); else ticks++;
        SEQ_STOP_B: if (over) go(SEQ_STOP_C); else ticks++;
        SEQ_STOP_C: begin
          if (over) begin
            if (xact >= 2'd2) begin
              r.done_res = 1'b1;
              xact = '0;
              byte_sel = 1'b0;
              go(SEQ_IDLE);
            end else begin
              xact = xact + 2'd1;
              byte_sel = 1'b0;
              go(SEQ_START_A);
            end
          end else ticks++;
        end
        default: go(SEQ_IDLE);
      endcase
      r.bad_digit = err_hold;
      levels_due.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task check_levels(logic [7:0] got);
      logic [6:0] g;
      logic [6:0] w;
      g = got[6:0];
      if (levels_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing due (%02h)", results_seen, got));
      end else begin
        w = levels_due.pop_front();
        for (int i = 0; i < 7; i++) begin
          if (g[i] !== w[i])
            report($sformatf("result %0d %s: got %b want %b",
                             results_seen, field_names[i], g[i], w[i]));
        end
      end
      results_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;

  line_level_board board;
  logic [8:0]      directed_q [$];   // {position, digit_code}
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              holds_asked = 0;
  int              holds_done = 0;
  int              hold_left = 0;
  int              cycles = 0;

  seven_segment_two_wire_sender #(
    .TICK_COUNT_BITS(8)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** seven_segment_two_wire_sender: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when one is asked for
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_levels(m_axis_tdata);
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // next tick item, shaped by where the sequencer will be when it is taken
  function automatic logic [15:0] make_tick(bit draining);
    logic       req;
    logic [1:0] pos;
    logic [6:0] dig;
    logic       din;
    int         pick;
    req = 1'b0;
    pos = 2'($urandom_range(0, 3));
    dig = 7'($urandom_range(0, 127));
    din = 1'($urandom_range(0, 1));
    if (board.idle()) begin
      if (!draining && directed_q.size() > 0) begin
        req = 1'b1;
        {pos, dig} = directed_q.pop_front();
      end else if (!draining) begin
        req = ($urandom_range(0, 1) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) dig = 7'($urandom_range(0, 15));
        else if (pick == 7) dig = DIGIT_BLANK;
        else dig = 7'($urandom_range(16, 126));
      end
    end else begin
      // requests while busy must be ignored
      req = !draining && ($urandom_range(0, 3) == 0);
      // device answers the acknowledge after a few ticks
      if (board.in_ack_wait()) din = ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
    end
    return {5'b0, din, dig, pos, req};
  endfunction

  // offer n_items ticks (directed requests first), then run the sequencer back to idle
  task automatic send_ticks(input int n_items, input int hold_at, input int pause_at);
    int taken;
    bit offering;
    bit draining;
    bit finished;
    taken = 0;
    offering = 1'b0;
    finished = 1'b0;
    while (!finished) begin
      @(posedge clk);
      if (offering && s_axis_tready) begin
        board.note_tick(s_axis_tdata);
        taken++;
        offering = 1'b0;
        if (taken == hold_at) holds_asked <= holds_asked + 1;
      end
      draining = (taken >= n_items) && (directed_q.size() == 0);
      if (offering) begin
        // item stays on the bus until taken
      end else if (draining && board.idle()) begin
        s_axis_tvalid <= 1'b0;
        finished = 1'b1;
      end else if (taken == pause_at && board.pending() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if ($urandom_range(0, 99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata <= make_tick(draining);
        s_axis_tvalid <= 1'b1;
        offering = 1'b1;
      end
    end
  endtask

  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] bright, input logic point,
                           input logic [7:0] half_bit, input logic [7:0] short_phase);
    put_reg(REG_BRIGHTNESS, {5'b0, bright});
    put_reg(REG_DOT_EN, {7'b0, point});
    put_reg(REG_HALF_BIT, half_bit);
    put_reg(REG_SHORT_PHASE, short_phase);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, one full update; long receiver hold-off fills the block,
    // later the sender pauses until every result is back
    send_idle_pct = 28;
    recv_idle_pct = 50;
    directed_q.push_back({2'd1, 7'd8});
    send_ticks(0, 60, 350);
    settle();

    // fastest timing, point and full brightness: lowest digit and a bad code
    send_idle_pct = 50;
    recv_idle_pct = 28;
    write_cfg(3'd7, 1'b1, 8'd1, 8'd1);
    directed_q.push_back({2'd0, 7'd0});
    directed_q.push_back({2'd3, 7'd16});
    send_ticks(100, -1, -1);
    settle();

    // zero tick registers act as one: highest digit and blank
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(3'd5, 1'b0, 8'd0, 8'd0);
    directed_q.push_back({2'd1, 7'd15});
    directed_q.push_back({2'd2, DIGIT_BLANK});
    send_ticks(150, -1, -1);
    settle();

    repeat (8) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.mismatches == 0) begin
      $display("** seven_segment_two_wire_sender: PASSED **");
    end else begin
      $display("** seven_segment_two_wire_sender: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ssts_pkg.sv
rtl/ssts_line_seq.sv
rtl/seven_segment_two_wire_sender.sv
sim/testbench.sv
